/* rtl/mbds_pkg.sv */
// ----------------------------------------------------------------------------
// mbds_pkg: shared constants, types and tables for the mip box downsampler
// Holds the size limits, the sRGB decode and threshold tables and the
// structs passed between the line store, the encoder and the output queue.
// ----------------------------------------------------------------------------
package mbds_pkg;

	// Largest source level width and height.
	localparam int MAX_WIDTH = 4096;
	// Fraction bits of a linear-light sample.
	localparam int LIN_W = 16;

	// Width of the size fields on the configuration port.
	localparam int SIZE_W = 13;
	// A clamped size, 1..MAX_WIDTH.
	localparam int DIM_W = $clog2(MAX_WIDTH + 1);
	// A source column or row position, 0..MAX_WIDTH-1.
	localparam int CNT_W = $clog2(MAX_WIDTH);
	// Line store depth: one row per target column.
	localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 2;
	localparam int TX_W = $clog2(LINE_DEPTH);

	// Output queue depth; also the number of results that may be in flight.
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int CREDIT_W = $clog2(FIFO_DEPTH + 1);

	// Encoder: one binary-search step per stage over the 8 code bits.
	localparam int ENC_STEPS = 8;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SRGB_MODE = 2'd2;

	typedef logic [LIN_W-1:0] lin_t;
	typedef logic [LIN_W:0] pair_t;
	typedef logic [255:0][LIN_W-1:0] lin_rom_t;

	// One line store row: upper pair sums of one target column.
	typedef struct packed {
		pair_t [2:0] rgb;
		logic [8:0] alpha;
	} line_word_t;

	// Block means handed to the encoder.
	typedef struct packed {
		logic srgb;
		lin_t [2:0] m;
		logic [7:0] alpha;
		logic done;
	} enc_in_t;

	// One finished target pixel.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic done;
	} pix_out_t;

	// Fifth power in 2.30 fixed point, truncating after each multiply.
	function automatic logic [63:0] fifth_q30(input logic [63:0] z);
		logic [63:0] p;
		p = z;
		for (int i = 0; i < 4; i++) begin
			p = (p * z) >> 30;
		end
		return p;
	endfunction

	// sRGB decode of n/510 to a linear value with LIN_W fraction bits.
	function automatic lin_t decode_step(input logic [9:0] n);
		logic [63:0] top;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] y;
		top = (64'd1 << LIN_W) - 64'd1;
		r = '0;
		mid = '0;
		if (n <= 10'd20) begin
			r = (((64'd200 * 64'(n)) << LIN_W) + 64'd658920) / 64'd1317840;
		end else begin
			x = ((64'd1000 * 64'(n) + 64'd28050) << 30) / 64'd538050;
			x2 = (x * x) >> 30;
			lo = '0;
			hi = 64'd1 << 30;
			// Fifth root of x2 by bisection: 2^30+1 candidates need 31 halvings.
			for (int k = 0; k < 31; k++) begin
				if (lo < hi) begin
					mid = (lo + hi + 64'd1) >> 1;
					if (fifth_q30(mid) <= x2) begin
						lo = mid;
					end else begin
						hi = mid - 64'd1;
					end
				end
			end
			y = (x2 * lo) >> 30;
			r = (y + (64'd1 << (29 - LIN_W))) >> (30 - LIN_W);
		end
		return (r > top) ? top[LIN_W-1:0] : r[LIN_W-1:0];
	endfunction

	function automatic lin_rom_t build_dec_rom();
		lin_rom_t rom;
		for (int k = 0; k < 256; k++) begin
			rom[k] = decode_step(10'(2 * k));
		end
		return rom;
	endfunction

	function automatic lin_rom_t build_thr_rom();
		lin_rom_t rom;
		rom[0] = '0;
		for (int k = 1; k < 256; k++) begin
			rom[k] = decode_step(10'(2 * k - 1));
		end
		return rom;
	endfunction

	// Byte to linear light.
	localparam lin_rom_t DEC_ROM = build_dec_rom();
	// Rounding thresholds: code k is reached when the mean is at least entry k.
	localparam lin_rom_t THR_ROM = build_thr_rom();

endpackage

/* rtl/mbds_line_store.sv */
// ----------------------------------------------------------------------------
// mbds_line_store: line memory of upper pair sums
// One row per target column, one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
module mbds_line_store (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [mbds_pkg::TX_W-1:0]     wr_addr,
	input  mbds_pkg::line_word_t          wr_data,
	input  logic                          rd_en,
	input  logic [mbds_pkg::TX_W-1:0]     rd_addr,
	output mbds_pkg::line_word_t          rd_data
);
	import mbds_pkg::*;

	line_word_t mem_q [LINE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/mbds_encode.sv */
// ----------------------------------------------------------------------------
// mbds_encode: linear-to-sRGB re-encoder
// Registers the block means, then finds each RGB code by an 8-step binary
// search over the threshold table, one step per pipeline stage.
// ----------------------------------------------------------------------------
module mbds_encode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  mbds_pkg::enc_in_t     in_data,
	output logic                  out_vld,
	output mbds_pkg::pix_out_t    out_data
);
	import mbds_pkg::*;

	typedef struct packed {
		enc_in_t base;
		logic [2:0][7:0] code;
	} enc_stage_t;

	logic       stg_valid_q [ENC_STEPS+1];
	enc_stage_t stg_data_q  [ENC_STEPS+1];

	// Entry stage: hold the means, codes start at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_valid_q[0] <= 1'b0;
		end else begin
			stg_valid_q[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		stg_data_q[0].base <= in_data;
		stg_data_q[0].code <= '0;
	end

	for (genvar k = 0; k < ENC_STEPS; k++) begin : g_step
		enc_stage_t nxt;

		// Try setting bit 7-k; keep it if the mean reaches that threshold.
		always_comb begin
			logic [7:0] cand;
			nxt = stg_data_q[k];
			for (int ch = 0; ch < 3; ch++) begin
				cand = stg_data_q[k].code[ch] | (8'd1 << (ENC_STEPS - 1 - k));
				if (THR_ROM[cand] <= stg_data_q[k].base.m[ch]) begin
					nxt.code[ch] = cand;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_valid_q[k+1] <= 1'b0;
			end else begin
				stg_valid_q[k+1] <= stg_valid_q[k];
			end
		end

		always_ff @(posedge clk) begin
			stg_data_q[k+1] <= nxt;
		end
	end

	// Linear mode passes the low byte of the mean.
	always_comb begin
		enc_stage_t last;
		last = stg_data_q[ENC_STEPS];
		out_data.red   = last.base.srgb ? last.code[0] : last.base.m[0][7:0];
		out_data.green = last.base.srgb ? last.code[1] : last.base.m[1][7:0];
		out_data.blue  = last.base.srgb ? last.code[2] : last.base.m[2][7:0];
		out_data.alpha = last.base.alpha;
		out_data.done  = last.base.done;
	end

	assign out_vld = stg_valid_q[ENC_STEPS];

endmodule

/* rtl/mbds_out_fifo.sv */
// ----------------------------------------------------------------------------
// mbds_out_fifo: result queue
// Small register queue that decouples the encoder from the output handshake.
// Space is reserved upstream, so a push always finds room.
// ----------------------------------------------------------------------------
module mbds_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mbds_pkg::pix_out_t  push_data,
	input  logic                pop,
	output logic                not_empty,
	output mbds_pkg::pix_out_t  head
);
	import mbds_pkg::*;

	pix_out_t            fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q;
	logic [FIFO_AW-1:0]  rd_ptr_q;
	logic [CREDIT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CREDIT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CREDIT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	assign not_empty = count_q != '0;
	assign head      = fifo_q[rd_ptr_q];

endmodule

/* rtl/mip_box_downsample_srgb_unit.sv */
// ----------------------------------------------------------------------------
// mip_box_downsample_srgb_unit: 2x2 box-filter mip level downsampler
// Streams one RGBA8 source level in raster order and emits the next smaller
// level, with optional sRGB-correct averaging of the color channels.
// ----------------------------------------------------------------------------
// Feed the source level one pixel per beat after writing its width, height
// and mode; each 2x2 block produces one target pixel when its lower right
// pixel arrives, and level_done marks the last pixel of the target level.
// The unit takes one pixel per clock while in_ready is high; the pixel
// completing a block passes stage 1, stage 2 (block sum with the line store
// read), nine encoder stages and the queue write before out_valid rises,
// and the result waits in a 16-entry output queue. in_ready drops
// only while 16 results are queued or in flight, so the input keeps flowing
// while the output is stalled until that depth is used up. The line store
// is never cleared: every row is written in an upper source row before the
// lower row reads it, so no clearing pass follows reset. A size write
// restarts the level; write configuration only while the unit is idle.
// ----------------------------------------------------------------------------
module mip_box_downsample_srgb_unit (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mbds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mbds_pkg::SIZE_W-1:0]       cfg_data,

	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        in_red,
	input  logic [7:0]                        in_green,
	input  logic [7:0]                        in_blue,
	input  logic [7:0]                        in_alpha,

	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        out_red,
	output logic [7:0]                        out_green,
	output logic [7:0]                        out_blue,
	output logic [7:0]                        out_alpha,
	output logic                              level_done
);
	import mbds_pkg::*;

	// ---------------- configuration ----------------
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             srgb_q;
	logic [DIM_W-1:0] size_clamped;
	logic             cfg_fire;
	logic             size_write;

	// ---------------- position and flow control ----------------
	logic [CNT_W-1:0]    col_q;
	logic [CNT_W-1:0]    row_q;
	logic [CREDIT_W-1:0] credit_q;
	logic                in_fire;
	logic                out_fire;

	// ---------------- accept stage decisions ----------------
	logic             w_one;
	logic             h_one;
	logic             col_in_pairs;
	logic             row_in_pairs;
	logic             has_pair;
	logic             left_take;
	logic             top_row;
	logic             bottom_row;
	logic             block;
	logic [TX_W-1:0]  tx;
	logic [TX_W-1:0]  ty;
	logic [CNT_W-1:0] tw_m1;
	logic [CNT_W-1:0] th_m1;
	logic             done_s0;
	logic             last_col;
	logic             last_row;
	lin_t [2:0]       v_rgb;

	// Left pixel of the current horizontal pair, in working form.
	lin_t [2:0]       held_rgb_q;
	logic [7:0]       held_alpha_q;

	// ---------------- stage 1: pair sums, line store access ----------------
	logic             valid_s1;
	lin_t [2:0]       v_rgb_s1;
	logic [7:0]       v_alpha_s1;
	logic             w_one_s1;
	logic             h_one_s1;
	logic             top_s1;
	logic             bottom_s1;
	logic [TX_W-1:0]  tx_s1;
	logic             done_s1;
	logic             srgb_s1;
	line_word_t       pair_cur;
	logic             line_wr;
	logic             line_rd;
	line_word_t       line_rd_data;

	// ---------------- stage 2: block sums and means ----------------
	logic             valid_s2;
	line_word_t       pair_s2;
	logic             h_one_s2;
	logic             done_s2;
	logic             srgb_s2;
	enc_in_t          enc_in;

	logic             enc_vld;
	pix_out_t         enc_out;
	logic             fifo_has;
	pix_out_t         fifo_head;

	// Configuration is always taken; the port writer must keep to idle periods.
	assign cfg_ready  = 1'b1;
	assign cfg_fire   = cfg_valid && cfg_ready;
	assign size_write = cfg_fire && ((cfg_index == CFG_SOURCE_WIDTH) ||
		(cfg_index == CFG_SOURCE_HEIGHT));

	// Clamp a size write: zero acts as one, anything above the limit as the limit.
	always_comb begin
		logic [31:0] size_ext;
		size_ext = 32'(cfg_data);
		if (size_ext == 32'd0) begin
			size_clamped = DIM_W'(1);
		end else if (size_ext > 32'(MAX_WIDTH)) begin
			size_clamped = DIM_W'(MAX_WIDTH);
		end else begin
			size_clamped = DIM_W'(size_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			srgb_q   <= 1'b0;
		end else if (cfg_fire) begin
			case (cfg_index)
				CFG_SOURCE_WIDTH: begin
					width_q <= size_clamped;
				end
				CFG_SOURCE_HEIGHT: begin
					height_q <= size_clamped;
				end
				CFG_SRGB_MODE: begin
					srgb_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Every result that can still reach the queue holds a credit, so the
	// queue never overflows and the pipeline never has to stall.
	assign in_ready = credit_q < CREDIT_W'(FIFO_DEPTH);
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// Classify the arriving pixel by its place in the source level.
	always_comb begin
		logic [CNT_W-1:0] tw_half;
		logic [CNT_W-1:0] th_half;
		w_one        = width_q == DIM_W'(1);
		h_one        = height_q == DIM_W'(1);
		col_in_pairs = DIM_W'(col_q) < {width_q[DIM_W-1:1], 1'b0};
		row_in_pairs = DIM_W'(row_q) < {height_q[DIM_W-1:1], 1'b0};

		// A pair closes on an odd column; a one-wide level pairs a pixel with itself.
		has_pair   = w_one || (col_q[0] && col_in_pairs);
		left_take  = !w_one && !col_q[0] && col_in_pairs;
		top_row    = !h_one && !row_q[0] && row_in_pairs;
		bottom_row = !h_one && row_q[0] && row_in_pairs;
		block      = has_pair && (h_one || bottom_row);

		tx = w_one ? '0 : TX_W'(col_q >> 1);
		ty = h_one ? '0 : TX_W'(row_q >> 1);

		tw_half = CNT_W'(width_q >> 1);
		th_half = CNT_W'(height_q >> 1);
		tw_m1   = (tw_half == '0) ? '0 : tw_half - CNT_W'(1);
		th_m1   = (th_half == '0) ? '0 : th_half - CNT_W'(1);
		done_s0 = (CNT_W'(tx) == tw_m1) && (CNT_W'(ty) == th_m1);

		last_col = DIM_W'(col_q) == (width_q - DIM_W'(1));
		last_row = DIM_W'(row_q) == (height_q - DIM_W'(1));

		// Decode color bytes to linear light in sRGB mode.
		v_rgb[0] = srgb_q ? DEC_ROM[in_red]   : LIN_W'(in_red);
		v_rgb[1] = srgb_q ? DEC_ROM[in_green] : LIN_W'(in_green);
		v_rgb[2] = srgb_q ? DEC_ROM[in_blue]  : LIN_W'(in_blue);
	end

	// Advance the raster position; a size write restarts the level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (size_write) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CREDIT_W'(in_fire && block) - CREDIT_W'(out_fire);
		end
	end

	// Hold the left pixel until its right partner arrives.
	always_ff @(posedge clk) begin
		if (in_fire && left_take) begin
			held_rgb_q   <= v_rgb;
			held_alpha_q <= in_alpha;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_fire && has_pair;
			valid_s2 <= valid_s1 && (h_one_s1 || bottom_s1);
		end
	end

	always_ff @(posedge clk) begin
		v_rgb_s1   <= v_rgb;
		v_alpha_s1 <= in_alpha;
		w_one_s1   <= w_one;
		h_one_s1   <= h_one;
		top_s1     <= top_row;
		bottom_s1  <= bottom_row;
		tx_s1      <= tx;
		done_s1    <= done_s0;
		srgb_s1    <= srgb_q;
	end

	// Pair sum. The held pixel stays put until the next even column is taken,
	// which is always later than this pixel leaves stage 1.
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			pair_cur.rgb[ch] = w_one_s1 ? {v_rgb_s1[ch], 1'b0} :
				({1'b0, held_rgb_q[ch]} + {1'b0, v_rgb_s1[ch]});
		end
		pair_cur.alpha = w_one_s1 ? {v_alpha_s1, 1'b0} :
			({1'b0, held_alpha_q} + {1'b0, v_alpha_s1});
	end

	// Upper rows store the pair, lower rows fetch it. Each column is written in
	// an earlier beat than the read of the same column, so the registered read
	// always returns the fresh entry.
	assign line_wr = valid_s1 && top_s1;
	assign line_rd = valid_s1 && bottom_s1;

	mbds_line_store u_line (
		.clk     (clk),
		.wr_en   (line_wr),
		.wr_addr (tx_s1),
		.wr_data (pair_cur),
		.rd_en   (line_rd),
		.rd_addr (tx_s1),
		.rd_data (line_rd_data)
	);

	always_ff @(posedge clk) begin
		pair_s2  <= pair_cur;
		h_one_s2 <= h_one_s1;
		done_s2  <= done_s1;
		srgb_s2  <= srgb_s1;
	end

	// Block sum and rounded mean; a one-high level counts its pair twice.
	always_comb begin
		logic [LIN_W+1:0] sum_rgb;
		logic [10:0]      sum_alpha;
		for (int ch = 0; ch < 3; ch++) begin
			sum_rgb = h_one_s2 ? {pair_s2.rgb[ch], 1'b0} :
				({1'b0, line_rd_data.rgb[ch]} + {1'b0, pair_s2.rgb[ch]});
			sum_rgb = sum_rgb + (LIN_W+2)'(2);
			enc_in.m[ch] = sum_rgb[LIN_W+1:2];
		end
		sum_alpha = h_one_s2 ? {1'b0, pair_s2.alpha, 1'b0} :
			({2'b00, line_rd_data.alpha} + {2'b00, pair_s2.alpha});
		sum_alpha    = sum_alpha + 11'd2;
		enc_in.alpha = sum_alpha[9:2];
		enc_in.done  = done_s2;
		enc_in.srgb  = srgb_s2;
	end

	mbds_encode u_enc (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (valid_s2),
		.in_data  (enc_in),
		.out_vld  (enc_vld),
		.out_data (enc_out)
	);

	mbds_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (enc_vld),
		.push_data (enc_out),
		.pop       (out_fire),
		.not_empty (fifo_has),
		.head      (fifo_head)
	);

	assign out_valid  = fifo_has;
	assign out_red    = fifo_head.red;
	assign out_green  = fifo_head.green;
	assign out_blue   = fifo_head.blue;
	assign out_alpha  = fifo_head.alpha;
	assign level_done = fifo_head.done;

`ifndef NO_ASSERTIONS
	// Outstanding results never exceed the queue depth.
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CREDIT_W'(FIFO_DEPTH))
		else $error("result credits exceed queue depth");

	// The raster position stays inside the configured level.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(DIM_W'(col_q) < width_q) && (DIM_W'(row_q) < height_q))
		else $error("raster position outside the level");

	// A pixel is either an upper-row store or a lower-row fetch, never both.
	a_line_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(line_wr && line_rd))
		else $error("line store written and read by one pixel");

	// A result can only leave while it holds a credit.
	a_out_credit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (credit_q != '0))
		else $error("result shown without a credit");

	// A pixel that completes a block leaves a credit behind.
	a_block_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && block && !out_fire) |=> (credit_q == $past(credit_q) + CREDIT_W'(1)))
		else $error("completed block did not take a credit");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 2x2 box-filter mip downsampler
// Streams source levels through the unit under random source gaps and sink
// stalls and scores every target pixel against a cycle-free model of the
// filter. The model has its own sRGB decode and threshold tables, line store
// and counters. A short table of directed beats comes first, then random levels.
// ----------------------------------------------------------------------------
module testbench;
	import mbds_pkg::*;

	// Index that maps to no register; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	// Random source pixels to send after the directed table.
	localparam int RANDOM_PIXELS = 1700;
	// Cycles to let the pipeline empty once the last target pixel is in.
	localparam int DRAIN_CYCLES = 32;
	// Hard stop; the slowest legal run stays well below this.
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	typedef struct packed {
		rgba_t color;
		logic done;
	} target_t;

	typedef enum bit {ROW_WRITE, ROW_PIXEL} row_kind_e;

	typedef struct packed {
		row_kind_e kind;
		logic [CFG_IDX_W-1:0] reg_index;
		logic [SIZE_W-1:0] reg_value;
		rgba_t color;
		logic known;
		target_t want;
	} plan_row_t;

	// Directed beats. Rows with known set carry the target pixel as read off
	// the filter definition; the rest are scored by the model.
	localparam plan_row_t DIRECTED_PLAN [32] = '{
		// 1x1 level after reset, linear: every pixel comes back as its own level
		'{ROW_PIXEL, '0, '0, 32'h00000000, 1'b1, {32'h00000000, 1'b1}},
		'{ROW_PIXEL, '0, '0, 32'hFFFFFFFF, 1'b1, {32'hFFFFFFFF, 1'b1}},
		'{ROW_PIXEL, '0, '0, 32'hA55A0FF0, 1'b1, {32'hA55A0FF0, 1'b1}},
		// same in sRGB mode: decode then encode must round-trip
		'{ROW_WRITE, CFG_SRGB_MODE, 13'd1, '0, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 32'h00000000, 1'b1, {32'h00000000, 1'b1}},
		'{ROW_PIXEL, '0, '0, 32'hFFFFFF80, 1'b1, {32'hFFFFFF80, 1'b1}},
		'{ROW_PIXEL, '0, '0, 32'h01020304, 1'b0, '0},
		// unmapped index, then mode with upper data bits set (bit 0 clear)
		'{ROW_WRITE, CFG_SPARE, 13'h1FFF, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_SRGB_MODE, 13'h1FFE, '0, 1'b0, '0},
		// width 0 acts as 1: single column used twice, 1x2 -> 1x1
		'{ROW_WRITE, CFG_SOURCE_WIDTH, 13'd0, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_SOURCE_HEIGHT, 13'd2, '0, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 32'h00000000, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 32'hFFFFFFFF, 1'b0, '0},
		// 3x3 in sRGB: odd trailing column and row are consumed silently
		'{ROW_WRITE, CFG_SRGB_MODE, 13'd1, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_SOURCE_WIDTH, 13'd3, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_SOURCE_HEIGHT, 13'd3, '0, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 32'h102030FF, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 32'h8040C000, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 32'h00FF7F01, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 32'hFF00807F, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 32'h3C3C3C3C, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 32'h55AA55AA, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 32'h11223344, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 32'hFFFFFFFF, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 32'h00000000, 1'b0, '0},
		// oversize width clamps to the maximum, height 0 acts as 1
		'{ROW_WRITE, CFG_SRGB_MODE, 13'd0, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_SOURCE_WIDTH, 13'h1FFF, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_SOURCE_HEIGHT, 13'd0, '0, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 32'hFFFFFFFF, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 32'hFFFFFFFF, 1'b1, {32'hFFFFFFFF, 1'b0}},
		'{ROW_PIXEL, '0, '0, 32'h00000000, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 32'h00000000, 1'b1, {32'h00000000, 1'b0}}
	};

	// Every input is known from time zero.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] in_red = '0;
	logic [7:0] in_green = '0;
	logic [7:0] in_blue = '0;
	logic [7:0] in_alpha = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic level_done;

	// Model state: register copies, source position, left pixel of the
	// current pair and the upper-row pair sums per target column.
	logic [SIZE_W-1:0] level_w;
	logic [SIZE_W-1:0] level_h;
	bit srgb_on;
	int unsigned col_pos;
	int unsigned row_pos;
	int unsigned left_px [4];
	int unsigned upper_sums [LINE_DEPTH][4];

	// Byte to linear light, and the linear floor of each output code.
	int unsigned lin_of_byte [256];
	int unsigned code_floor [256];

	target_t expected_targets [$];

	bit src_gaps = 1'b1;
	bit sink_stalls = 1'b1;
	int unsigned sink_wait = 0;
	int unsigned cycle_count = 0;
	int unsigned fail_count = 0;
	int unsigned pixels_sent = 0;
	int unsigned srgb_pixels = 0;
	int unsigned targets_seen = 0;
	int unsigned level_settings = 0;

	mip_box_downsample_srgb_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_red     (in_red),
		.in_green   (in_green),
		.in_blue    (in_blue),
		.in_alpha   (in_alpha),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.out_alpha  (out_alpha),
		.level_done (level_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// --- sRGB tables ---------------------------------------------------------

	// z^5 in 2.30 fixed point, each product truncated back to 30 fraction bits.
	function automatic longint unsigned pow5_q30(input longint unsigned z);
		longint unsigned acc;
		acc = z;
		repeat (4) acc = (acc * z) >> 30;
		return acc;
	endfunction

	// Linear value of sRGB code n/510, LIN_W fraction bits, saturated.
	// The power 2.4 is taken as x^2 * x^(2/5), the fifth root by bisection.
	function automatic int unsigned srgb_to_linear(input int unsigned n);
		longint unsigned ceiling;
		longint unsigned res;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned y;
		ceiling = (64'd1 << LIN_W) - 64'd1;
		if (n <= 20) begin
			// linear toe: n/510/12.92 as an exact rational, rounded
			res = (((64'd200 * n) << LIN_W) + 64'd658920) / 64'd1317840;
		end else begin
			x = ((64'd1000 * n + 64'd28050) << 30) / 64'd538050;
			x2 = (x * x) >> 30;
			lo = 0;
			hi = 64'd1 << 30;
			while (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				if (pow5_q30(mid) <= x2) begin
					lo = mid;
				end else begin
					hi = mid - 64'd1;
				end
			end
			y = (x2 * lo) >> 30;
			res = (y + (64'd1 << (29 - LIN_W))) >> (30 - LIN_W);
		end
		return (res > ceiling) ? int'(ceiling) : int'(res);
	endfunction

	// Re-encode: the code is the count of thresholds the mean reaches.
	function automatic int unsigned linear_to_code(input int unsigned m);
		int unsigned code;
		code = 0;
		for (int k = 1; k < 256; k++) begin
			if (m >= code_floor[k]) begin
				code++;
			end
		end
		return code;
	endfunction

	// --- model of the filter -------------------------------------------------

	function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] v);
		if (v == 0) begin
			return 1;
		end
		return (v > MAX_WIDTH) ? MAX_WIDTH : int'(v);
	endfunction

	// Advance the model by one source pixel; hit is set when that pixel
	// closes a 2x2 block and target holds the filtered pixel.
	task automatic predict_target_pixel(input rgba_t color, output bit hit,
			output target_t target);
		int unsigned w;
		int unsigned h;
		int unsigned tw;
		int unsigned th;
		int unsigned c;
		int unsigned r;
		int unsigned tx;
		int unsigned ty;
		int unsigned m;
		int unsigned code;
		int unsigned raw [4];
		int unsigned v [4];
		int unsigned pr [4];
		int unsigned s [4];
		logic [7:0] outb [4];
		bit got_pair;
		w = clamp_dim(level_w);
		h = clamp_dim(level_h);
		tw = (w / 2 != 0) ? w / 2 : 1;
		th = (h / 2 != 0) ? h / 2 : 1;
		c = (col_pos < w) ? col_pos : 0;
		r = (row_pos < h) ? row_pos : 0;
		tx = 0;
		ty = 0;
		got_pair = 1'b0;
		hit = 1'b0;
		target = '0;
		raw[0] = color.red;
		raw[1] = color.green;
		raw[2] = color.blue;
		raw[3] = color.alpha;
		// alpha never goes through the sRGB tables
		for (int ch = 0; ch < 4; ch++) begin
			v[ch] = (srgb_on && ch < 3) ? lin_of_byte[raw[ch]] : raw[ch];
		end

		// horizontal pair: a single column pairs with itself
		if (w == 1) begin
			for (int ch = 0; ch < 4; ch++) pr[ch] = 2 * v[ch];
			got_pair = 1'b1;
		end else if (c < 2 * tw) begin
			if (c % 2 == 0) begin
				for (int ch = 0; ch < 4; ch++) left_px[ch] = v[ch];
			end else begin
				for (int ch = 0; ch < 4; ch++) pr[ch] = left_px[ch] + v[ch];
				tx = c / 2;
				got_pair = 1'b1;
			end
		end

		// vertical: the upper row parks its pair sums, the lower row adds them
		if (got_pair) begin
			if (h == 1) begin
				for (int ch = 0; ch < 4; ch++) s[ch] = 2 * pr[ch];
				hit = 1'b1;
			end else if (r < 2 * th) begin
				if (r % 2 == 0) begin
					for (int ch = 0; ch < 4; ch++) upper_sums[tx][ch] = pr[ch];
				end else begin
					for (int ch = 0; ch < 4; ch++) s[ch] = upper_sums[tx][ch] + pr[ch];
					ty = r / 2;
					hit = 1'b1;
				end
			end
		end

		// advance raster position, wrapping at the end of the level
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) begin
				r = 0;
			end
		end
		col_pos = c;
		row_pos = r;

		if (hit) begin
			for (int ch = 0; ch < 4; ch++) begin
				m = (s[ch] + 2) >> 2;
				code = (srgb_on && ch < 3) ? linear_to_code(m) : m;
				outb[ch] = code[7:0];
			end
			target.color = {outb[0], outb[1], outb[2], outb[3]};
			target.done = (tx == tw - 1) && (ty == th - 1);
		end
	endtask

	// --- source side ---------------------------------------------------------

	function automatic logic [7:0] rand_channel();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic rgba_t rand_color();
		return {rand_channel(), rand_channel(), rand_channel(), rand_channel()};
	endfunction

	// A size well beyond the small levels: maximum, oversize or just large.
	function automatic int unsigned big_size();
		case ($urandom_range(0, 3))
			0: return MAX_WIDTH;
			1: return 8191;
			2: return $urandom_range(MAX_WIDTH + 1, 8191);
			default: return $urandom_range(64, MAX_WIDTH - 1);
		endcase
	endfunction

	// Send one source pixel. Drop valid for the idle gap only when there
	// is one, so back-to-back beats keep valid high across the edge.
	task automatic push_pixel(input rgba_t color, input bit known, input target_t want);
		int unsigned gap;
		bit hit;
		target_t target;
		gap = src_gaps ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_red <= color.red;
		in_green <= color.green;
		in_blue <= color.blue;
		in_alpha <= color.alpha;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// beat taken at this edge: run the model in acceptance order
		predict_target_pixel(color, hit, target);
		if (hit) begin
			expected_targets.push_back(known ? want : target);
		end
		pixels_sent++;
		if (srgb_on) begin
			srgb_pixels++;
		end
	endtask

	// Drop valid, wait out every pending target pixel, then give the
	// pipeline time to finish pixels that produce nothing.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_targets.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write; size writes restart the level in the model too.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SOURCE_WIDTH, CFG_SOURCE_HEIGHT: begin
				if (idx == CFG_SOURCE_WIDTH) begin
					level_w = data;
				end else begin
					level_h = data;
				end
				col_pos = 0;
				row_pos = 0;
				for (int ch = 0; ch < 4; ch++) left_px[ch] = 0;
			end
			CFG_SRGB_MODE: begin
				srgb_on = data[0];
			end
			default: begin
			end
		endcase
		// wait idle before returning so the next write never re-raises valid in this step
		@(posedge clk);
	endtask

	// --- sink side and scoring -----------------------------------------------

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Score accepted beats against the oldest expectation; stall ready for a
	// freshly drawn number of cycles after each beat.
	always @(posedge clk) begin
		target_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				targets_seen++;
				if (expected_targets.size() == 0) begin
					$display("%0t: unexpected target pixel %02h%02h%02h%02h done %0b",
						$time, out_red, out_green, out_blue, out_alpha, level_done);
					fail_count++;
				end else begin
					want = expected_targets.pop_front();
					check_field("red", want.color.red, out_red);
					check_field("green", want.color.green, out_green);
					check_field("blue", want.color.blue, out_blue);
					check_field("alpha", want.color.alpha, out_alpha);
					check_field("level_done", want.done, level_done);
				end
				sink_wait = sink_stalls ? $urandom_range(0, 15) : 0;
			end else if (sink_wait != 0) begin
				sink_wait--;
			end
			out_ready <= (sink_wait == 0);
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// --- stimulus ------------------------------------------------------------

	initial begin
		int unsigned random_sent;
		int unsigned n;
		int unsigned area;
		int unsigned shape;
		int unsigned w_data;
		int unsigned h_data;
		bit drained_once;

		random_sent = 0;
		drained_once = 1'b0;
		for (int k = 0; k < 256; k++) begin
			lin_of_byte[k] = srgb_to_linear(2 * k);
		end
		code_floor[0] = 0;
		for (int k = 1; k < 256; k++) begin
			code_floor[k] = srgb_to_linear(2 * k - 1);
		end

		// model starts from the reset register values
		level_w = 1;
		level_h = 1;
		srgb_on = 1'b0;
		col_pos = 0;
		row_pos = 0;
		for (int ch = 0; ch < 4; ch++) left_px[ch] = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table; registers change only with the unit idle
		foreach (DIRECTED_PLAN[i]) begin
			if (DIRECTED_PLAN[i].kind == ROW_WRITE) begin
				drain_results();
				write_reg(DIRECTED_PLAN[i].reg_index, DIRECTED_PLAN[i].reg_value);
			end else begin
				push_pixel(DIRECTED_PLAN[i].color, DIRECTED_PLAN[i].known,
					DIRECTED_PLAN[i].want);
			end
		end

		// random levels: mostly small whole levels, a few huge partial ones,
		// and now and then a mode flip in the middle of a running level
		while (random_sent < RANDOM_PIXELS) begin
			drain_results();
			src_gaps = ($urandom_range(0, 3) != 0);
			sink_stalls = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 5) == 0) begin
				// mode changes at once; sums already stored are not converted
				write_reg(CFG_SRGB_MODE, SIZE_W'($urandom));
				n = $urandom_range(1, 40);
			end else begin
				shape = $urandom_range(0, 9);
				case (shape)
					0: begin
						w_data = big_size();
						h_data = $urandom_range(0, 3);
					end
					1: begin
						h_data = big_size();
						w_data = $urandom_range(0, 3);
					end
					default: begin
						w_data = $urandom_range(0, 12);
						h_data = $urandom_range(0, 12);
					end
				endcase
				write_reg(CFG_SOURCE_WIDTH, SIZE_W'(w_data));
				write_reg(CFG_SOURCE_HEIGHT, SIZE_W'(h_data));
				write_reg(CFG_SRGB_MODE, SIZE_W'($urandom));
				if (shape < 2) begin
					// too big to finish: take a slice of the first rows
					n = $urandom_range(16, 300);
				end else begin
					// one to three whole levels, sometimes a partial tail
					area = clamp_dim(SIZE_W'(w_data)) * clamp_dim(SIZE_W'(h_data));
					n = area * $urandom_range(1, 3);
					if ($urandom_range(0, 3) == 0) begin
						n += $urandom_range(1, area);
					end
				end
			end
			// stop the random part right at its pixel budget
			if (n > RANDOM_PIXELS - random_sent) begin
				n = RANDOM_PIXELS - random_sent;
			end
			level_settings++;
			for (int k = 0; k < n; k++) begin
				// hold the source until the sink has caught up, mid-level
				if (!drained_once && n > 1 && k == n / 2) begin
					drain_results();
					drained_once = 1'b1;
				end else if ($urandom_range(0, 299) == 0) begin
					drain_results();
				end
				push_pixel(rand_color(), 1'b0, '0);
				random_sent++;
			end
		end

		drain_results();
		$display("Sent %0d source pixels (%0d in sRGB mode) over %0d random level settings",
			pixels_sent, srgb_pixels, level_settings);
		$display("Scored %0d target pixels, %0d mismatches", targets_seen, fail_count);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/mbds_pkg.sv
rtl/mbds_line_store.sv
rtl/mbds_encode.sv
rtl/mbds_out_fifo.sv
rtl/mip_box_downsample_srgb_unit.sv
bench/testbench.sv
